[hdl/uart_packet_framer_crc16_core_macros.svh]
// Assertion macros shared by the framer's checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef UART_PACKET_FRAMER_CRC16_CORE_MACROS_SVH
`define UART_PACKET_FRAMER_CRC16_CORE_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define UPF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("upf check failed");

// Clocked check that also holds during reset.
`define UPF_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("upf check failed");

`endif

[hdl/upf_pkg.sv]
// Types, constants and the byte-wide CRC-16 function for the packet framer.
// No dependencies.
package upf_pkg;

	localparam int unsigned BURST_MAX = 7;
	localparam int unsigned CNT_W     = 3;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [8:0]  FRAME_OVERHEAD = 9'd6;
	localparam logic [7:0]  LEN_BIAS       = 8'd2;

	typedef enum logic [1:0] {
		REG_START_BYTE = 2'd0,
		REG_VERSION    = 2'd1,
		REG_MAX_FRAME  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       rejected;
	} result_t;

	// Results of one item, entry 0 goes out first.
	typedef struct packed {
		result_t [BURST_MAX-1:0] ent;
		logic [CNT_W-1:0]        cnt;
	} burst_t;

	function automatic result_t mk_result(input logic [7:0] b, input logic fe,
			input logic rj);
		result_t r;
		r.out_byte  = b;
		r.frame_end = fe;
		r.rejected  = rj;
		return r;
	endfunction

	// CRC-16, MSB first, one byte per call.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[hdl/upf_ifs.sv]
// Valid/ready channel interfaces for framer input items and result bytes.
// No dependencies.
interface upf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] payload_length;
	logic [7:0] packet_type;

	modport source(output valid, output data_byte, output payload_length,
		output packet_type, input ready);
	modport sink(input valid, input data_byte, input payload_length,
		input packet_type, output ready);
endinterface

interface upf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       rejected;

	modport source(output valid, output out_byte, output frame_end, output rejected,
		input ready);
	modport sink(input valid, input out_byte, input frame_end, input rejected,
		output ready);
endinterface

[hdl/upf_emit.sv]
// Result buffer: holds the results of one item and sends one per transfer.
// Depends on upf_pkg and upf_out_if.
module upf_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  upf_pkg::burst_t   load_burst,
	output logic              can_load,
	upf_out_if.source         framed
);

	upf_pkg::result_t [upf_pkg::BURST_MAX-1:0] ent_q;
	logic [upf_pkg::CNT_W-1:0]                 cnt_q;
	logic                                      fire;

	assign fire     = framed.valid && framed.ready;
	// Refill when empty, or when the last entry leaves this cycle.
	assign can_load = (cnt_q == '0) ||
		((cnt_q == upf_pkg::CNT_W'(1)) && framed.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_burst.cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - upf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_burst.ent;
		end else if (fire) begin
			for (int i = 0; i < upf_pkg::BURST_MAX - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	assign framed.valid     = (cnt_q != '0);
	assign framed.out_byte  = ent_q[0].out_byte;
	assign framed.frame_end = ent_q[0].frame_end;
	assign framed.rejected  = ent_q[0].rejected;

endmodule

[hdl/uart_packet_framer_crc16_core.sv]
// Packet framer with CRC-16: input register, single-pass frame builder, result buffer.
// The first result of an item passes the input register and is then loaded into the result buffer when it can load.
// Payload items and dropped items go at one per cycle while the result buffer can load; an item
// with n results holds the input until all n have transferred (first item 5 to 7, or 1 when
// rejected; last payload item 3), set by the one-byte-per-transfer result buffer.
// Reset clears channel state, the packet state (CRC to 0xFFFF) and config to defaults.
module uart_packet_framer_crc16_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	upf_in_if.sink     payload,
	upf_out_if.source  framed
);

	// configuration
	logic [7:0] start_q;
	logic [7:0] version_q;
	logic [8:0] max_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 8'd0;
			version_q   <= 8'd0;
			max_frame_q <= 9'd64;
		end else if (cfg_wr_en) begin
			case (upf_pkg::reg_idx_t'(cfg_index))
				upf_pkg::REG_START_BYTE: start_q     <= cfg_data[7:0];
				upf_pkg::REG_VERSION:    version_q   <= cfg_data[7:0];
				upf_pkg::REG_MAX_FRAME:  max_frame_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic        v_s1;
	logic [7:0]  data_s1;
	logic [7:0]  len_s1;
	logic [7:0]  type_s1;
	logic [15:0] hdr_crc_s1;
	logic        over_s1;
	logic        adv;
	logic        can_load;
	logic        in_fire;
	logic [7:0]  in_lbyte;

	assign adv           = v_s1 && can_load;
	assign payload.ready = !v_s1 || can_load;
	assign in_fire       = payload.valid && payload.ready;
	assign in_lbyte      = payload.payload_length + upf_pkg::LEN_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Length and type CRC are only used on a first item; computed for every item.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1    <= payload.data_byte;
			len_s1     <= payload.payload_length;
			type_s1    <= payload.packet_type;
			hdr_crc_s1 <= upf_pkg::crc_feed(upf_pkg::crc_feed(upf_pkg::CRC_INIT, in_lbyte),
				payload.packet_type);
			over_s1    <= ({1'b0, payload.payload_length} + upf_pkg::FRAME_OVERHEAD)
				> max_frame_q;
		end
	end

	// packet state
	logic [7:0]  bl_q, bl_n, bl_dec, lbyte_s1;
	logic [15:0] crc_q, crc_n, crc4, crc5, crc_mid;
	logic        disc_q, disc_n;
	upf_pkg::burst_t nb;

	assign bl_dec   = bl_q - 8'd1;
	assign lbyte_s1 = len_s1 + upf_pkg::LEN_BIAS;
	assign crc4     = upf_pkg::crc_feed(hdr_crc_s1, version_q);
	assign crc5     = upf_pkg::crc_feed(crc4, data_s1);
	assign crc_mid  = upf_pkg::crc_feed(crc_q, data_s1);

	always_comb begin
		nb     = '0;
		bl_n   = bl_q;
		crc_n  = crc_q;
		disc_n = disc_q;
		if (bl_q != 8'd0) begin
			bl_n = bl_dec;
			if (disc_q) begin
				if (bl_dec == 8'd0) begin
					disc_n = 1'b0;
				end
			end else begin
				nb.ent[0] = upf_pkg::mk_result(data_s1, 1'b0, 1'b0);
				if (bl_dec == 8'd0) begin
					nb.ent[1] = upf_pkg::mk_result(crc_mid[7:0], 1'b0, 1'b0);
					nb.ent[2] = upf_pkg::mk_result(crc_mid[15:8], 1'b1, 1'b0);
					nb.cnt    = upf_pkg::CNT_W'(3);
					crc_n     = upf_pkg::CRC_INIT;
				end else begin
					nb.cnt = upf_pkg::CNT_W'(1);
					crc_n  = crc_mid;
				end
			end
		end else if (over_s1) begin
			// oversized: the first item stands for payload byte one
			nb.ent[0] = upf_pkg::mk_result(8'h00, 1'b1, 1'b1);
			nb.cnt    = upf_pkg::CNT_W'(1);
			crc_n     = upf_pkg::CRC_INIT;
			if (len_s1 > 8'd1) begin
				bl_n   = len_s1 - 8'd1;
				disc_n = 1'b1;
			end else begin
				disc_n = 1'b0;
			end
		end else begin
			disc_n    = 1'b0;
			nb.ent[0] = upf_pkg::mk_result(start_q, 1'b0, 1'b0);
			nb.ent[1] = upf_pkg::mk_result(lbyte_s1, 1'b0, 1'b0);
			nb.ent[2] = upf_pkg::mk_result(type_s1, 1'b0, 1'b0);
			nb.ent[3] = upf_pkg::mk_result(version_q, 1'b0, 1'b0);
			if (len_s1 == 8'd0) begin
				nb.ent[4] = upf_pkg::mk_result(crc4[7:0], 1'b0, 1'b0);
				nb.ent[5] = upf_pkg::mk_result(crc4[15:8], 1'b1, 1'b0);
				nb.cnt    = upf_pkg::CNT_W'(6);
				crc_n     = upf_pkg::CRC_INIT;
			end else begin
				nb.ent[4] = upf_pkg::mk_result(data_s1, 1'b0, 1'b0);
				if (len_s1 == 8'd1) begin
					nb.ent[5] = upf_pkg::mk_result(crc5[7:0], 1'b0, 1'b0);
					nb.ent[6] = upf_pkg::mk_result(crc5[15:8], 1'b1, 1'b0);
					nb.cnt    = upf_pkg::CNT_W'(7);
					crc_n     = upf_pkg::CRC_INIT;
				end else begin
					nb.cnt = upf_pkg::CNT_W'(5);
					bl_n   = len_s1 - 8'd1;
					crc_n  = crc5;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_q   <= 8'd0;
			crc_q  <= upf_pkg::CRC_INIT;
			disc_q <= 1'b0;
		end else if (adv) begin
			bl_q   <= bl_n;
			crc_q  <= crc_n;
			disc_q <= disc_n;
		end
	end

	upf_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv),
		.load_burst (nb),
		.can_load   (can_load),
		.framed     (framed)
	);

endmodule

[hdl/upf_chk.sv]
// Port-level checks for the packet framer, bound to the top level.
// Depends on uart_packet_framer_crc16_core_macros.svh.
`include "uart_packet_framer_crc16_core_macros.svh"

module upf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       rejected
);

	// a stalled result holds until its transfer
	`UPF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end) && $stable(rejected))

	// a reject result closes the frame and carries a zero byte
	`UPF_ASSERT(a_reject_form, clk, arst_n, out_valid && rejected |-> frame_end && (out_byte == 8'd0))

	// nothing is offered once reset has been seen at an edge
	`UPF_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid)

endmodule

bind uart_packet_framer_crc16_core upf_chk u_upf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (framed.valid),
	.out_ready (framed.ready),
	.out_byte  (framed.out_byte),
	.frame_end (framed.frame_end),
	.rejected  (framed.rejected)
);

[tb/sv/uart_packet_framer_crc16_core_tb.sv]
// Self-checking testbench for uart_packet_framer_crc16_core: drives packets with bursty
// valid/ready traffic, predicts every framed byte and the CRC, and checks the output stream.
// Depends on upf_pkg (hdl/upf_pkg.sv) and the channel interfaces (hdl/upf_ifs.sv).
module uart_packet_framer_crc16_core_tb;
	import upf_pkg::*;

	localparam logic [1:0]  REG_NONE    = 2'd3;
	localparam int unsigned DRAIN_TAIL  = 10;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned MAX_SHOWN   = 10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] payload_length;
		logic [7:0] packet_type;
	} framer_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	upf_in_if  in_ch();
	upf_out_if out_ch();

	uart_packet_framer_crc16_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.payload(in_ch),
		.framed(out_ch)
	);

	always #6 clk = ~clk;

	framer_item_t tx_items[$];
	result_t      frame_bytes_due[$];

	// predictor state and config shadow
	logic [7:0]  pl_remaining;
	logic [15:0] crc_acc;
	logic        drop_mode;
	logic [7:0]  sh_start;
	logic [7:0]  sh_version;
	logic [8:0]  sh_max;

	// stimulus generator: items left in the packet being queued
	int unsigned gen_left;

	int unsigned mismatches;
	int unsigned stall_cycles;
	int unsigned burst_left;
	int unsigned gap_left;
	logic [15:0] ready_pat;
	int unsigned pat_age;

	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	task automatic queue_result(input logic [7:0] b, input logic fe, input logic rj);
		frame_bytes_due.push_back('{out_byte: b, frame_end: fe, rejected: rj});
	endtask

	task automatic queue_crc();
		queue_result(crc_acc[7:0], 1'b0, 1'b0);
		queue_result(crc_acc[15:8], 1'b1, 1'b0);
		crc_acc = CRC_INIT;
	endtask

	task automatic frame_model_step(input framer_item_t it);
		logic [7:0] lbyte;
		logic [8:0] need;
		need = {1'b0, it.payload_length} + FRAME_OVERHEAD;
		if (pl_remaining != 8'd0) begin
			pl_remaining = pl_remaining - 8'd1;
			if (drop_mode) begin
				if (pl_remaining == 8'd0)
					drop_mode = 1'b0;
			end else begin
				queue_result(it.data_byte, 1'b0, 1'b0);
				crc_acc = crc16_next(crc_acc, it.data_byte);
				if (pl_remaining == 8'd0)
					queue_crc();
			end
		end else begin
			drop_mode = 1'b0;
			if (need > sh_max) begin
				// header counts as the first payload byte of the dropped packet
				queue_result(8'h00, 1'b1, 1'b1);
				if (it.payload_length > 8'd1) begin
					pl_remaining = it.payload_length - 8'd1;
					drop_mode = 1'b1;
				end
				crc_acc = CRC_INIT;
			end else begin
				lbyte = it.payload_length + LEN_BIAS;
				crc_acc = CRC_INIT;
				queue_result(sh_start, 1'b0, 1'b0);
				queue_result(lbyte, 1'b0, 1'b0);
				crc_acc = crc16_next(crc_acc, lbyte);
				queue_result(it.packet_type, 1'b0, 1'b0);
				crc_acc = crc16_next(crc_acc, it.packet_type);
				queue_result(sh_version, 1'b0, 1'b0);
				crc_acc = crc16_next(crc_acc, sh_version);
				if (it.payload_length == 8'd0) begin
					queue_crc();
				end else begin
					queue_result(it.data_byte, 1'b0, 1'b0);
					crc_acc = crc16_next(crc_acc, it.data_byte);
					if (it.payload_length == 8'd1)
						queue_crc();
					else
						pl_remaining = it.payload_length - 8'd1;
				end
			end
		end
	endtask

	// sender: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin : drive_items
		framer_item_t cur;
		framer_item_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= 8'h00;
			in_ch.payload_length <= 8'h00;
			in_ch.packet_type <= 8'h00;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				cur = '{data_byte: in_ch.data_byte, payload_length: in_ch.payload_length,
					packet_type: in_ch.packet_type};
				frame_model_step(cur);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (tx_items.size() != 0 && gap_left == 0) begin
					nxt = tx_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= nxt.data_byte;
					in_ch.payload_length <= nxt.payload_length;
					in_ch.packet_type <= nxt.packet_type;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_ch.valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end
			end
		end
	end

	// receiver: rotating ready pattern, reshuffled whenever pat_age wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			ready_pat <= '1;
			pat_age <= 0;
		end else begin
			out_ch.ready <= ready_pat[0];
			if (pat_age == 47) begin
				pat_age <= 0;
				case ($urandom_range(0, 3))
					0: ready_pat <= '1;
					1: ready_pat <= 16'($urandom) | (16'h1 << $urandom_range(0, 15));
					2: ready_pat <= 16'($urandom & $urandom) | (16'h1 << $urandom_range(0, 15));
					default: ready_pat <= 16'h8000;
				endcase
			end else begin
				ready_pat <= {ready_pat[0], ready_pat[15:1]};
				pat_age <= pat_age + 1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_byte: out_ch.out_byte, frame_end: out_ch.frame_end,
				rejected: out_ch.rejected};
			if (frame_bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: byte=%02h end=%b rej=%b",
						got.out_byte, got.frame_end, got.rejected);
			end else begin
				want = frame_bytes_due.pop_front();
				if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
						got.rejected !== want.rejected) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("result mismatch: expected byte=%02h end=%b rej=%b, got byte=%02h end=%b rej=%b",
							want.out_byte, want.frame_end, want.rejected,
							got.out_byte, got.frame_end, got.rejected);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("[uart_packet_framer_crc16_core] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_START_BYTE: sh_start = val[7:0];
			REG_VERSION:    sh_version = val[7:0];
			REG_MAX_FRAME:  sh_max = val;
			default:        ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_item(input logic [7:0] d, input logic [7:0] len, input logic [7:0] ty);
		tx_items.push_back('{data_byte: d, payload_length: len, packet_type: ty});
	endtask

	task automatic wait_drained(input int unsigned tail);
		do
			@(negedge clk);
		while (tx_items.size() != 0 || in_ch.valid || frame_bytes_due.size() != 0);
		repeat (tail) @(negedge clk);
	endtask

	// queues 'budget' items of random packets; may stop mid-packet
	task automatic queue_random(input int unsigned budget);
		framer_item_t it;
		int unsigned len;
		while (budget != 0) begin
			it.data_byte = 8'($urandom);
			it.payload_length = 8'($urandom);
			it.packet_type = 8'($urandom);
			if (gen_left == 0) begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 40);
				it.payload_length = 8'(len);
				gen_left = (len > 1) ? len - 1 : 0;
			end else begin
				gen_left--;
			end
			budget--;
			tx_items.push_back(it);
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.payload_length = 8'h00;
		in_ch.packet_type = 8'h00;
		out_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_START_BYTE;
		cfg_data = 9'd0;
		pl_remaining = 8'd0;
		crc_acc = CRC_INIT;
		drop_mode = 1'b0;
		sh_start = 8'h00;
		sh_version = 8'h00;
		sh_max = 9'd64;
		gen_left = 0;
		mismatches = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// limit 10: length 4 just fits, length 5 is rejected
		cfg_write(REG_START_BYTE, 9'h1A5);
		cfg_write(REG_VERSION, 9'h1FF);
		cfg_write(REG_MAX_FRAME, 9'd10);
		push_item(8'hFF, 8'd0, 8'h00);
		push_item(8'h00, 8'd1, 8'hFF);
		push_item(8'hFF, 8'd4, 8'h5A);
		push_item(8'h00, 8'hFF, 8'hFF);
		push_item(8'h80, 8'h00, 8'h00);
		push_item(8'h01, 8'hAA, 8'h55);
		push_item(8'h12, 8'd5, 8'h3C);
		push_item(8'h34, 8'd0, 8'd0);
		push_item(8'h56, 8'd0, 8'd0);
		push_item(8'h78, 8'd0, 8'd0);
		push_item(8'h9A, 8'd0, 8'd0);
		wait_drained(DRAIN_TAIL);

		// smallest legal limit: only empty packets pass; unused index is ignored
		cfg_write(REG_NONE, 9'h1FF);
		cfg_write(REG_START_BYTE, 9'h000);
		cfg_write(REG_VERSION, 9'h000);
		cfg_write(REG_MAX_FRAME, 9'd6);
		push_item(8'hC3, 8'd0, 8'h81);
		push_item(8'hC3, 8'd1, 8'h81);
		push_item(8'h11, 8'd2, 8'h22);
		push_item(8'h33, 8'd7, 8'h44);
		wait_drained(DRAIN_TAIL);

		// limit below the header size: everything is rejected
		cfg_write(REG_MAX_FRAME, 9'd0);
		push_item(8'h00, 8'd0, 8'h00);
		push_item(8'hFF, 8'd3, 8'hFF);
		push_item(8'hEE, 8'd3, 8'h01);
		push_item(8'hDD, 8'd3, 8'h02);
		wait_drained(DRAIN_TAIL);

		// long payload exactly at the limit
		cfg_write(REG_START_BYTE, 9'h0FF);
		cfg_write(REG_MAX_FRAME, 9'd30);
		push_item(8'($urandom), 8'd24, 8'($urandom));
		for (int i = 0; i < 23; i++)
			push_item(8'($urandom), 8'($urandom), 8'($urandom));
		wait_drained(DRAIN_TAIL);

		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(0, 7))
				0:       cfg_write(REG_MAX_FRAME, 9'd6);
				1:       cfg_write(REG_MAX_FRAME, 9'd0);
				2:       cfg_write(REG_MAX_FRAME, 9'd261);
				3:       cfg_write(REG_MAX_FRAME, 9'd511);
				4:       cfg_write(REG_MAX_FRAME, 9'd64);
				default: cfg_write(REG_MAX_FRAME, 9'($urandom_range(6, 261)));
			endcase
			cfg_write(REG_START_BYTE, 9'($urandom));
			cfg_write(REG_VERSION, 9'($urandom));
			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_NONE, 9'($urandom));
			if (ph == 3) begin
				// sender holds off until the output has fully drained
				queue_random(12);
				wait_drained(0);
				queue_random(12);
			end else begin
				queue_random(24);
			end
			wait_drained(DRAIN_TAIL);
		end

		if (frame_bytes_due.size() != 0) begin
			$display("%0d expected results never arrived", frame_bytes_due.size());
			mismatches += frame_bytes_due.size();
		end
		if (mismatches == 0)
			$display("[uart_packet_framer_crc16_core] OK");
		else
			$display("[uart_packet_framer_crc16_core] ERROR");
		$finish;
	end

endmodule
